@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AST_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define AST_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/dmf_pkg.sv @@
`default_nettype none
package dmf_pkg;
  localparam logic signed [31:0] PdgNegMu = 32'sd13;
  localparam logic signed [31:0] PdgPosMu = -32'sd13;
  localparam logic signed [31:0] PdgPosK  = 32'sd321;
  localparam logic signed [31:0] PdgNegK  = -32'sd321;

  localparam logic [1:0] KindNegMu = 2'd0;
  localparam logic [1:0] KindPosMu = 2'd1;
  localparam logic [1:0] KindPosK  = 2'd2;
  localparam logic [1:0] KindNegK  = 2'd3;

  localparam logic [2:0] LastPair = 3'd5;

  typedef struct packed {
    logic signed [31:0] pdg_code;
    logic signed [19:0] mom_x;
    logic signed [19:0] mom_y;
    logic signed [19:0] mom_z;
    logic               last_particle;
  } in_t;

  typedef struct packed {
    logic        event_accepted;
    logic [31:0] accepted_total;
    logic        list_overflow;
  } out_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } vec_t;

  typedef struct packed {
    logic load;
    logic init;
    logic mul;
    logic next_pair;
    logic next_combo;
    logic finish;
    logic acc;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic dot_ok;
    logic last_pair;
    logic last_combo;
  } sts_t;

  function automatic logic [1:0] pair_a(input logic [2:0] p);
    case (p)
      3'd0, 3'd1, 3'd3: pair_a = KindNegMu;
      3'd2, 3'd4:       pair_a = KindPosMu;
      default:          pair_a = KindPosK;
    endcase
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] p);
    case (p)
      3'd0:       pair_b = KindPosMu;
      3'd1, 3'd2: pair_b = KindPosK;
      default:    pair_b = KindNegK;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/dmf_ctrl.sv @@
`default_nettype none
module dmf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic          last_i,
  input  wire dmf_pkg::sts_t sts_i,
  output dmf_pkg::cmd_t      cmd_o,
  output logic               busy
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StChk  = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StAdd  = 2'd3;

  logic [1:0] state_q, state_d;

  assign busy = (state_q != StIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_i) state_d = StChk;
        end
      end
      StChk: begin
        if (sts_i.empty) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAdd;
      end
      StAdd: begin
        if (sts_i.dot_ok) begin
          if (sts_i.last_pair) begin
            cmd_o.finish = 1'b1;
            cmd_o.acc    = 1'b1;
            state_d      = StIdle;
          end else begin
            cmd_o.next_pair = 1'b1;
            state_d         = StMul;
          end
        end else if (sts_i.last_combo) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else begin
          cmd_o.next_combo = 1'b1;
          state_d          = StMul;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/dmf_dpath.sv @@
`default_nettype none
module dmf_dpath #(
  parameter int MaxPerKind = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dmf_pkg::in_t  in_i,
  input  wire dmf_pkg::cmd_t cmd_i,
  output dmf_pkg::sts_t      sts_o,
  output dmf_pkg::out_t      res_o,
  output logic               strobe_o
);
  localparam int CW = $clog2(MaxPerKind + 1);
  localparam int IW = (MaxPerKind > 1) ? $clog2(MaxPerKind) : 1;

  dmf_pkg::vec_t st_q [4][MaxPerKind];
  logic [CW-1:0] cnt_q [4];
  logic [IW-1:0] idx_q [4];
  logic [2:0]    pair_q;
  logic          ovf_q;
  logic [31:0]   tot_q;
  logic signed [39:0] px_q, py_q, pz_q;
  dmf_pkg::out_t res_q;
  logic          strobe_q;

  logic          hit;
  logic [1:0]    kind;
  logic [CW-1:0] n;
  dmf_pkg::vec_t va, vb, vin;
  logic [3:0]    at_end;
  logic [3:0]    carry;
  logic signed [41:0] dot;
  logic [31:0]   tot_nx;

  always_comb begin
    hit  = 1'b1;
    kind = dmf_pkg::KindNegMu;
    if (in_i.pdg_code == dmf_pkg::PdgNegMu)      kind = dmf_pkg::KindNegMu;
    else if (in_i.pdg_code == dmf_pkg::PdgPosMu) kind = dmf_pkg::KindPosMu;
    else if (in_i.pdg_code == dmf_pkg::PdgPosK)  kind = dmf_pkg::KindPosK;
    else if (in_i.pdg_code == dmf_pkg::PdgNegK)  kind = dmf_pkg::KindNegK;
    else hit = 1'b0;
  end

  assign n   = cnt_q[kind];
  assign vin = '{x: in_i.mom_x, y: in_i.mom_y, z: in_i.mom_z};
  assign va  = st_q[dmf_pkg::pair_a(pair_q)][idx_q[dmf_pkg::pair_a(pair_q)]];
  assign vb  = st_q[dmf_pkg::pair_b(pair_q)][idx_q[dmf_pkg::pair_b(pair_q)]];

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      at_end[m] = (idx_q[m] == IW'(cnt_q[m] - CW'(1)));
    end
    carry[3] = 1'b1;
    for (int m = 2; m >= 0; m--) begin
      carry[m] = carry[m+1] & at_end[m+1];
    end
  end

  assign dot = 42'(px_q) + 42'(py_q) + 42'(pz_q);
  assign tot_nx = tot_q + 32'(cmd_i.acc);

  assign sts_o.empty      = (cnt_q[0] == '0) || (cnt_q[1] == '0) ||
                            (cnt_q[2] == '0) || (cnt_q[3] == '0);
  assign sts_o.dot_ok     = !dot[41];
  assign sts_o.last_pair  = (pair_q == dmf_pkg::LastPair);
  assign sts_o.last_combo = &at_end;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && hit && (n < CW'(MaxPerKind))) begin
      st_q[kind][n[IW-1:0]] <= vin;
    end
    if (cmd_i.mul) begin
      px_q <= $signed(va.x) * $signed(vb.x);
      py_q <= $signed(va.y) * $signed(vb.y);
      pz_q <= $signed(va.z) * $signed(vb.z);
    end
    if (cmd_i.finish) begin
      res_q.event_accepted <= cmd_i.acc;
      res_q.accepted_total <= tot_nx;
      res_q.list_overflow  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < 4; m++) begin
        cnt_q[m] <= '0;
        idx_q[m] <= '0;
      end
      pair_q   <= '0;
      ovf_q    <= 1'b0;
      tot_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.finish;
      if (cmd_i.load && hit) begin
        if (n < CW'(MaxPerKind)) cnt_q[kind] <= n + CW'(1);
        else                     ovf_q <= 1'b1;
      end
      if (cmd_i.init) begin
        for (int m = 0; m < 4; m++) idx_q[m] <= '0;
        pair_q <= '0;
      end
      if (cmd_i.next_pair) pair_q <= pair_q + 3'd1;
      if (cmd_i.next_combo) begin
        pair_q <= '0;
        for (int m = 0; m < 4; m++) begin
          if (carry[m]) begin
            idx_q[m] <= at_end[m] ? '0 : idx_q[m] + IW'(1);
          end
        end
      end
      if (cmd_i.finish) begin
        tot_q <= tot_nx;
        ovf_q <= 1'b0;
        for (int m = 0; m < 4; m++) cnt_q[m] <= '0;
      end
    end
  end

  assign res_o    = res_q;
  assign strobe_o = strobe_q;
endmodule
`default_nettype wire

@@ hw/rtl/dimuon_dikaon_hemisphere_event_filter.sv @@
// Particles: one per transfer, taken whenever the filter is not busy.
// Marked particle: busy while the lists are checked; each pair check is a multiply
//   state then a sum state, up to 6 pairs for each of the muon/kaon
//   combinations, then the result strobes for one cycle.
// Results cannot be stalled. Reset empties the lists (clears their counts) and clears overflow and total.
`default_nettype none
`include "assert_macros.svh"
module dimuon_dikaon_hemisphere_event_filter #(
  parameter int MAX_PER_KIND = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire dmf_pkg::in_t in_i,
  output logic              strobe_o,
  output dmf_pkg::out_t     res_o
);
  dmf_pkg::cmd_t cmd;
  dmf_pkg::sts_t sts;

  dmf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .last_i (in_i.last_particle),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  dmf_dpath #(.MaxPerKind(MAX_PER_KIND)) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .res_o    (res_o),
    .strobe_o (strobe_o)
  );

  `AST_NXT(a_fin_strobe, cmd.finish, strobe_o)
  `AST_NXT(a_last_busy, start && !busy && in_i.last_particle, busy)
  `AST_IMP(a_strobe_idle, strobe_o, !$past(strobe_o) && !busy)
endmodule
`default_nettype wire

@@ test/dimuon_dikaon_hemisphere_event_filter_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module dimuon_dikaon_hemisphere_event_filter_tb;
  localparam int InW = $bits(dmf_pkg::in_t);

  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } mom_t;

  class event_scoreboard;
    mom_t lists[4][$];
    bit   dropped;
    logic [31:0] n_accepted;
    dmf_pkg::out_t pending[$];
    int   errors;

    function new();
      dropped = 0;
      n_accepted = '0;
      errors = 0;
    endfunction

    function bit same_side(mom_t a, mom_t b);
      longint d;
      d = longint'(a.x) * longint'(b.x) + longint'(a.y) * longint'(b.y)
        + longint'(a.z) * longint'(b.z);
      return d >= 0;
    endfunction

    function bit find_combo();
      mom_t nm[$];
      mom_t pm[$];
      mom_t pk[$];
      mom_t nk[$];
      nm = lists[dmf_pkg::KindNegMu];
      pm = lists[dmf_pkg::KindPosMu];
      pk = lists[dmf_pkg::KindPosK];
      nk = lists[dmf_pkg::KindNegK];
      for (int i = 0; i < nm.size(); i++)
        for (int j = 0; j < pm.size(); j++) begin
          if (!same_side(nm[i], pm[j])) continue;
          for (int k = 0; k < pk.size(); k++) begin
            if (!same_side(nm[i], pk[k]) || !same_side(pm[j], pk[k])) continue;
            for (int l = 0; l < nk.size(); l++)
              if (same_side(nm[i], nk[l]) && same_side(pm[j], nk[l]) &&
                  same_side(pk[k], nk[l]))
                return 1;
          end
        end
      return 0;
    endfunction

    function void note_particle(dmf_pkg::in_t p);
      int kind;
      mom_t m;
      dmf_pkg::out_t r;
      kind = -1;
      if (p.pdg_code == dmf_pkg::PdgNegMu) kind = dmf_pkg::KindNegMu;
      else if (p.pdg_code == dmf_pkg::PdgPosMu) kind = dmf_pkg::KindPosMu;
      else if (p.pdg_code == dmf_pkg::PdgPosK) kind = dmf_pkg::KindPosK;
      else if (p.pdg_code == dmf_pkg::PdgNegK) kind = dmf_pkg::KindNegK;
      if (kind >= 0) begin
        if (lists[kind].size() < 8) begin
          m.x = p.mom_x;
          m.y = p.mom_y;
          m.z = p.mom_z;
          lists[kind].insert(lists[kind].size(), m);
        end else begin
          dropped = 1;
        end
      end
      if (p.last_particle) begin
        r.event_accepted = find_combo();
        if (r.event_accepted) n_accepted++;
        r.accepted_total = n_accepted;
        r.list_overflow = dropped;
        pending.insert(pending.size(), r);
        for (int i = 0; i < 4; i++) lists[i].delete();
        dropped = 0;
      end
    endfunction

    function void check_decision(dmf_pkg::out_t got);
      dmf_pkg::out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.event_accepted !== e.event_accepted) begin
        $error("event_accepted: expected %0d, got %0d", e.event_accepted,
               got.event_accepted);
        errors++;
      end
      if (got.accepted_total !== e.accepted_total) begin
        $error("accepted_total: expected %0d, got %0d", e.accepted_total,
               got.accepted_total);
        errors++;
      end
      if (got.list_overflow !== e.list_overflow) begin
        $error("list_overflow: expected %0d, got %0d", e.list_overflow,
               got.list_overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  dmf_pkg::in_t  in_i = '0;
  logic strobe_o;
  dmf_pkg::out_t res_o;
  int   gap_pct = 0;
  event_scoreboard sb = new();

  always #6 clk_i = ~clk_i;

  dimuon_dikaon_hemisphere_event_filter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .strobe_o(strobe_o), .res_o(res_o)
  );

  always @(posedge clk_i)
    if (rst_ni && strobe_o) sb.check_decision(res_o);

  function automatic dmf_pkg::in_t junk();
    return dmf_pkg::in_t'(InW'({$urandom, $urandom, $urandom}));
  endfunction

  task automatic send_particle(dmf_pkg::in_t p);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      in_i  <= junk();
      @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_particle(p);
    @(negedge clk_i);
  endtask

  function automatic logic signed [19:0] rand_comp();
    case ($urandom_range(5))
      0: return 20'sh80000;
      1: return 20'sh7FFFF;
      2: return '0;
      3: return 20'($urandom_range(200) - 100);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic dmf_pkg::in_t make_particle(logic signed [31:0] code, bit last);
    dmf_pkg::in_t p;
    p.pdg_code = code;
    p.mom_x = rand_comp();
    p.mom_y = rand_comp();
    p.mom_z = rand_comp();
    p.last_particle = last;
    return p;
  endfunction

  function automatic logic signed [31:0] rand_code();
    case ($urandom_range(9))
      0, 1: return dmf_pkg::PdgNegMu;
      2, 3: return dmf_pkg::PdgPosMu;
      4, 5: return dmf_pkg::PdgPosK;
      6, 7: return dmf_pkg::PdgNegK;
      8: return $urandom;
      default: return 32'sd211;
    endcase
  endfunction

  // event with one of each species (in a common hemisphere when aligned), plus random extras
  task automatic send_event(int extras, bit aligned);
    dmf_pkg::in_t q[$];
    dmf_pkg::in_t p;
    logic signed [31:0] codes[4] = '{dmf_pkg::PdgNegMu, dmf_pkg::PdgPosMu,
                                     dmf_pkg::PdgPosK, dmf_pkg::PdgNegK};
    for (int i = 0; i < 4; i++) begin
      p = make_particle(codes[i], 0);
      if (aligned) begin
        p.mom_x = 20'($urandom_range(524287));
        p.mom_y = 20'($urandom_range(524287));
        p.mom_z = 20'($urandom_range(524287));
      end
      q.insert(q.size(), p);
    end
    for (int i = 0; i < extras; i++)
      q.insert($urandom_range(q.size()), make_particle(rand_code(), 0));
    q[q.size() - 1].last_particle = 1;
    foreach (q[i]) send_particle(q[i]);
  endtask

  initial begin
    dmf_pkg::in_t p;
    int sent;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // empty event, lone non-listed marked particle
    send_particle(make_particle(32'sd22, 1));
    // all four species, aligned zero vectors (dot product zero)
    p = '0;
    p.pdg_code = dmf_pkg::PdgNegMu; send_particle(p);
    p.pdg_code = dmf_pkg::PdgPosMu; send_particle(p);
    p.pdg_code = dmf_pkg::PdgPosK;  send_particle(p);
    p.pdg_code = dmf_pkg::PdgNegK;  p.last_particle = 1; send_particle(p);
    // max-magnitude vectors, opposite hemispheres
    p = '{dmf_pkg::PdgNegMu, 20'sh80000, 20'sh80000, 20'sh80000, 1'b0}; send_particle(p);
    p = '{dmf_pkg::PdgPosMu, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b0}; send_particle(p);
    p = '{dmf_pkg::PdgPosK, 20'sh80000, 20'sh80000, 20'sh80000, 1'b0}; send_particle(p);
    p = '{dmf_pkg::PdgNegK, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b1}; send_particle(p);
    // overflow: nine muons, marked particle is a kaon
    for (int i = 0; i < 9; i++) send_particle(make_particle(dmf_pkg::PdgNegMu, 0));
    send_particle(make_particle(dmf_pkg::PdgPosK, 1));
    p = '{32'h7FFFFFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b1}; send_particle(p);
    p = '{32'h80000000, 20'sh80000, 20'sh80000, 20'sh80000, 1'b1}; send_particle(p);
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 0) ? 0 : (ph == 2) ? 0 : (ph == 1) ? 69 : 13;
      while (sent < 150 * (ph + 1)) begin
        int extras;
        extras = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        if ($urandom_range(9) == 0) begin
          for (int i = 0; i < extras; i++) send_particle(make_particle(rand_code(), 0));
          send_particle(make_particle(rand_code(), 1));
          sent += extras + 1;
        end else begin
          send_event(extras, $urandom_range(1));
          sent += extras + 4;
        end
      end
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #500ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dmf_pkg.sv
hw/rtl/dmf_ctrl.sv
hw/rtl/dmf_dpath.sv
hw/rtl/dimuon_dikaon_hemisphere_event_filter.sv
test/dimuon_dikaon_hemisphere_event_filter_tb.sv
